@@ rtl/ssid_pkg.sv @@
// Shared types, constants and opcodes of the sparse-set integer domain.
package ssid_pkg;

	localparam int DOMAIN_SIZE = 1024;
	localparam int IDX_W       = $clog2(DOMAIN_SIZE);
	localparam int CNT_W       = IDX_W + 1;

	localparam logic [2:0] OP_QUERY   = 3'd0;
	localparam logic [2:0] OP_REMOVE  = 3'd1;
	localparam logic [2:0] OP_BELOW   = 3'd2;
	localparam logic [2:0] OP_ABOVE   = 3'd3;
	localparam logic [2:0] OP_ASSIGN  = 3'd4;
	localparam logic [2:0] OP_RESTORE = 3'd5;
	localparam logic [2:0] OP_REINIT  = 3'd6;

	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_SPAN = 1'b1;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] operand_value;
		logic [10:0]        restore_count;
		logic signed [31:0] restore_min;
		logic signed [31:0] restore_max;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic               found;
		logic [9:0]         position;
		logic [10:0]        live_count;
		logic signed [31:0] cur_min;
		logic signed [31:0] cur_max;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_LOOKUP,
		ST_DECIDE,
		ST_BOUNDS,
		ST_SCAN,
		ST_CUT_RD,
		ST_CUT_CHK,
		ST_SW_RD,
		ST_SW_W1,
		ST_SW_W2,
		ST_DONE
	} state_t;

endpackage

@@ rtl/ssid_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module ssid_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/sparse_set_integer_domain.sv @@
// Top level of the sparse-set integer domain with its sequencer and caches.
//
// Requests arrive on req (req_valid/req_ready) and each one produces exactly
// one beat on rsp (rsp_valid/rsp_ready). Configuration writes arrive on the
// cfg channel, which is always ready; register 0 is the base value and
// register 1 the initial span, and both take effect at the next reinit.
// The block works on one request at a time and holds req_ready low while
// busy. A finished result sits in an output register, so a new request is
// taken while the receiver stalls; the sequencer only waits when a second
// result is ready before the first beat was taken.
// Each table has a single read port, so the sequencer steps through its
// states: a query looks up and decides, a restore only loads the count and
// bounds, and a point remove or assign of a live value also swaps two
// entries, followed by a rescan when a removed value was a cached bound.
// A threshold removal scans the live entries, checks each one and swaps out
// each removed entry, then rescans. Reinit rewrites both tables; after reset
// the same fill runs with req_ready low, and the domain is then 0 to 1023.
module sparse_set_integer_domain (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  ssid_pkg::req_t        req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output ssid_pkg::rsp_t        rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_data
);

	ssid_pkg::state_t state_q, state_d;

	logic signed [31:0] base_q, abase_q, min_q, max_q, lo_q, hi_q;
	logic [10:0] span_q, aspan_q, cnt_q, idx_q;
	logic [2:0] op_q;
	logic signed [31:0] v_q;
	logic ok_q, found_q, init_rsp_q, rv_q, first_q, surv_q, rescan_q;
	logic [9:0] pos_q, swi_q, swj_q, oi_q;
	logic rsp_valid_q;
	ssid_pkg::rsp_t rsp_q;

	logic dense_we, pos_we;
	logic [9:0] dense_waddr, dense_wdata, dense_raddr, dense_rdata;
	logic [9:0] pos_waddr, pos_wdata, pos_raddr, pos_rdata;

	logic [10:0] span_sat, span_eff, cnt_m1;
	logic [32:0] room, d;
	logic win, live, above, pass, fail, rm, issue, fin, bnd;
	logic signed [31:0] sv;

	ssid_ram #(.DEPTH(ssid_pkg::DOMAIN_SIZE), .WIDTH(ssid_pkg::IDX_W)) u_dense (
		.clk(clk), .we(dense_we), .waddr(dense_waddr), .wdata(dense_wdata),
		.raddr(dense_raddr), .rdata(dense_rdata)
	);

	ssid_ram #(.DEPTH(ssid_pkg::DOMAIN_SIZE), .WIDTH(ssid_pkg::IDX_W)) u_pos (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(pos_raddr), .rdata(pos_rdata)
	);

	always_comb begin
		span_sat = (span_q > 11'(ssid_pkg::DOMAIN_SIZE)) ? 11'(ssid_pkg::DOMAIN_SIZE) : span_q;
		room     = 33'h0_8000_0000 - {base_q[31], base_q};
		span_eff = ({22'b0, span_sat} > room) ? room[10:0] : span_sat;
		d        = {v_q[31], v_q} - {abase_q[31], abase_q};
		win      = !d[32] && (d[31:0] < {21'b0, aspan_q});
		live     = win && ({1'b0, pos_rdata} < cnt_q);
		cnt_m1   = cnt_q - 11'd1;
		above    = (op_q == ssid_pkg::OP_ABOVE);
		pass     = above ? (v_q >= max_q) : (v_q <= min_q);
		fail     = above ? (v_q < min_q) : (v_q > max_q);
		sv       = abase_q + {22'b0, dense_rdata};
		rm       = above ? (sv > v_q) : (sv < v_q);
		issue    = idx_q < cnt_q;
		fin      = !issue && !rv_q;
		bnd      = (v_q == min_q) || (v_q == max_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssid_pkg::ST_INIT: begin
				if (idx_q[9:0] == 10'(ssid_pkg::DOMAIN_SIZE - 1)) begin
					state_d = init_rsp_q ? ssid_pkg::ST_DONE : ssid_pkg::ST_IDLE;
				end
			end
			ssid_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (req.op)
						ssid_pkg::OP_QUERY, ssid_pkg::OP_REMOVE, ssid_pkg::OP_ASSIGN:
							state_d = ssid_pkg::ST_LOOKUP;
						ssid_pkg::OP_BELOW, ssid_pkg::OP_ABOVE:
							state_d = ssid_pkg::ST_BOUNDS;
						ssid_pkg::OP_REINIT: state_d = ssid_pkg::ST_INIT;
						default: state_d = ssid_pkg::ST_DONE;
					endcase
				end
			end
			ssid_pkg::ST_LOOKUP: state_d = ssid_pkg::ST_DECIDE;
			ssid_pkg::ST_DECIDE: begin
				state_d = ssid_pkg::ST_DONE;
				if (op_q == ssid_pkg::OP_REMOVE && live && cnt_q != 11'd1) begin
					state_d = ssid_pkg::ST_SW_RD;
				end
				if (op_q == ssid_pkg::OP_ASSIGN && live) begin
					state_d = ssid_pkg::ST_SW_RD;
				end
			end
			ssid_pkg::ST_BOUNDS: begin
				state_d = (pass || fail) ? ssid_pkg::ST_DONE : ssid_pkg::ST_SCAN;
			end
			ssid_pkg::ST_SCAN: begin
				if (fin) begin
					state_d = (!rescan_q && surv_q) ? ssid_pkg::ST_CUT_RD : ssid_pkg::ST_DONE;
				end
			end
			ssid_pkg::ST_CUT_RD: begin
				state_d = issue ? ssid_pkg::ST_CUT_CHK : ssid_pkg::ST_SCAN;
			end
			ssid_pkg::ST_CUT_CHK: state_d = rm ? ssid_pkg::ST_SW_RD : ssid_pkg::ST_CUT_RD;
			ssid_pkg::ST_SW_RD: state_d = ssid_pkg::ST_SW_W1;
			ssid_pkg::ST_SW_W1: state_d = ssid_pkg::ST_SW_W2;
			ssid_pkg::ST_SW_W2: begin
				case (op_q)
					ssid_pkg::OP_REMOVE: state_d = bnd ? ssid_pkg::ST_SCAN : ssid_pkg::ST_DONE;
					ssid_pkg::OP_BELOW, ssid_pkg::OP_ABOVE: state_d = ssid_pkg::ST_CUT_RD;
					default: state_d = ssid_pkg::ST_DONE;
				endcase
			end
			ssid_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ssid_pkg::ST_IDLE;
				end
			end
			default: state_d = ssid_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		dense_we    = 1'b0;
		pos_we      = 1'b0;
		dense_waddr = swi_q;
		dense_wdata = dense_rdata;
		pos_waddr   = dense_rdata;
		pos_wdata   = swi_q;
		dense_raddr = idx_q[9:0];
		pos_raddr   = d[9:0];
		case (state_q)
			ssid_pkg::ST_INIT: begin
				dense_we    = 1'b1;
				pos_we      = 1'b1;
				dense_waddr = idx_q[9:0];
				dense_wdata = idx_q[9:0];
				pos_waddr   = idx_q[9:0];
				pos_wdata   = idx_q[9:0];
			end
			ssid_pkg::ST_IDLE: req_ready = 1'b1;
			ssid_pkg::ST_SW_RD: dense_raddr = swj_q;
			ssid_pkg::ST_SW_W1: begin
				dense_we = 1'b1;
				pos_we   = 1'b1;
			end
			ssid_pkg::ST_SW_W2: begin
				dense_we    = 1'b1;
				pos_we      = 1'b1;
				dense_waddr = swj_q;
				dense_wdata = oi_q;
				pos_waddr   = oi_q;
				pos_wdata   = swj_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			span_q <= 11'(ssid_pkg::DOMAIN_SIZE);
		end else if (cfg_valid) begin
			if (cfg_index == ssid_pkg::CFG_BASE) begin
				base_q <= cfg_data;
			end else begin
				span_q <= cfg_data[10:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssid_pkg::ST_INIT;
			abase_q     <= '0;
			aspan_q     <= 11'(ssid_pkg::DOMAIN_SIZE);
			cnt_q       <= 11'(ssid_pkg::DOMAIN_SIZE);
			min_q       <= '0;
			max_q       <= 32'(ssid_pkg::DOMAIN_SIZE - 1);
			idx_q       <= '0;
			init_rsp_q  <= 1'b0;
			rv_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ssid_pkg::ST_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ssid_pkg::ST_INIT: idx_q <= idx_q + 11'd1;
				ssid_pkg::ST_IDLE: begin
					if (req_valid) begin
						op_q    <= req.op;
						v_q     <= req.operand_value;
						found_q <= 1'b0;
						pos_q   <= '0;
						case (req.op)
							ssid_pkg::OP_QUERY, ssid_pkg::OP_REMOVE, ssid_pkg::OP_ASSIGN,
							ssid_pkg::OP_BELOW, ssid_pkg::OP_ABOVE: begin
								ok_q <= 1'b1;
							end
							ssid_pkg::OP_RESTORE: begin
								ok_q  <= 1'b1;
								cnt_q <= (req.restore_count > aspan_q) ? aspan_q : req.restore_count;
								min_q <= req.restore_min;
								max_q <= req.restore_max;
							end
							ssid_pkg::OP_REINIT: begin
								ok_q       <= 1'b1;
								abase_q    <= base_q;
								aspan_q    <= span_eff;
								cnt_q      <= span_eff;
								min_q      <= base_q;
								max_q      <= base_q + {21'b0, span_eff} - 32'd1;
								idx_q      <= '0;
								init_rsp_q <= 1'b1;
							end
							default: ok_q <= 1'b0;
						endcase
					end
				end
				ssid_pkg::ST_DECIDE: begin
					swi_q <= pos_rdata;
					oi_q  <= d[9:0];
					case (op_q)
						ssid_pkg::OP_QUERY: begin
							if (live && v_q >= min_q && v_q <= max_q) begin
								found_q <= 1'b1;
								pos_q   <= pos_rdata;
							end
						end
						ssid_pkg::OP_REMOVE: begin
							swj_q <= cnt_m1[9:0];
							if (live && cnt_q == 11'd1) begin
								ok_q <= 1'b0;
							end
						end
						ssid_pkg::OP_ASSIGN: begin
							swj_q <= '0;
							if (!live) begin
								ok_q <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				ssid_pkg::ST_BOUNDS: begin
					if (fail && !pass) begin
						ok_q <= 1'b0;
					end
					idx_q    <= '0;
					rv_q     <= 1'b0;
					surv_q   <= 1'b0;
					rescan_q <= 1'b0;
				end
				ssid_pkg::ST_SCAN: begin
					rv_q <= issue;
					if (issue) begin
						idx_q <= idx_q + 11'd1;
					end
					if (rv_q) begin
						first_q <= 1'b0;
						if (above ? (sv <= v_q) : (sv >= v_q)) begin
							surv_q <= 1'b1;
						end
						if (first_q || sv < lo_q) begin
							lo_q <= sv;
						end
						if (first_q || sv > hi_q) begin
							hi_q <= sv;
						end
					end
					if (fin) begin
						if (rescan_q) begin
							min_q <= lo_q;
							max_q <= hi_q;
						end else if (surv_q) begin
							idx_q <= '0;
						end else begin
							ok_q <= 1'b0;
						end
					end
				end
				ssid_pkg::ST_CUT_RD: begin
					if (!issue) begin
						idx_q    <= '0;
						rv_q     <= 1'b0;
						first_q  <= 1'b1;
						rescan_q <= 1'b1;
					end
				end
				ssid_pkg::ST_CUT_CHK: begin
					if (rm) begin
						swi_q <= idx_q[9:0];
						swj_q <= cnt_m1[9:0];
						oi_q  <= dense_rdata;
					end else begin
						idx_q <= idx_q + 11'd1;
					end
				end
				ssid_pkg::ST_SW_W2: begin
					if (op_q == ssid_pkg::OP_ASSIGN) begin
						cnt_q <= 11'd1;
						min_q <= v_q;
						max_q <= v_q;
					end else begin
						cnt_q <= cnt_m1;
					end
					if (op_q == ssid_pkg::OP_REMOVE) begin
						idx_q    <= '0;
						rv_q     <= 1'b0;
						first_q  <= 1'b1;
						rescan_q <= 1'b1;
					end
				end
				ssid_pkg::ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q <= '{ok_q, found_q, pos_q, cnt_q, min_q, max_q};
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= aspan_q)
		else $error("live count exceeds the active span");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ssid_pkg::ST_DONE)
		else $error("result raised outside the done state");

	a_tables_together: assert property (@(posedge clk) disable iff (!arst_n)
		dense_we == pos_we)
		else $error("dense and position tables written apart");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssid_pkg::ST_INIT) |-> !req_ready)
		else $error("request taken during table fill");

endmodule

@@ verif/sparse_set_integer_domain_test.sv @@
// Self-checking testbench of the sparse-set integer domain with its own domain predictor.
module sparse_set_integer_domain_test;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	ssid_pkg::req_t req = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	ssid_pkg::rsp_t rsp;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic           cfg_index = ssid_pkg::CFG_BASE;
	logic [31:0]    cfg_data = '0;

	sparse_set_integer_domain dut (.*);

	always #6 clk = ~clk;

	// Shadow of the domain, kept in step with accepted requests.
	longint reg_base = 0;
	int     reg_span = 1024;
	longint win_base;
	int     win_span;
	int     dense_tab [ssid_pkg::DOMAIN_SIZE];
	int     slot_tab [ssid_pkg::DOMAIN_SIZE];
	int     live_n;
	longint lo_bound, hi_bound;

	ssid_pkg::rsp_t expected_results [$];
	int     error_count = 0;
	int     items_sent = 0;
	int     results_checked = 0;
	int     burst_left = 0;
	int     idle_cycles = 0;
	int     ready_cycle = 0;
	int     stall_pct = 0;

	typedef struct {
		int     n;
		longint lo;
		longint hi;
	} trail_t;
	trail_t trail [$];

	function automatic longint sext(logic [31:0] x);
		return longint'($signed(x));
	endfunction

	function automatic void domain_reinit();
		longint room;
		int sp;
		room = 64'sd2147483647 - reg_base + 1;
		sp = (reg_span > ssid_pkg::DOMAIN_SIZE) ? ssid_pkg::DOMAIN_SIZE : reg_span;
		if (sp > room)
			sp = int'(room);
		for (int i = 0; i < ssid_pkg::DOMAIN_SIZE; i++) begin
			dense_tab[i] = i;
			slot_tab[i] = i;
		end
		win_base = reg_base;
		win_span = sp;
		live_n = sp;
		lo_bound = reg_base;
		hi_bound = sext(32'(reg_base + sp - 1));
	endfunction

	function automatic longint value_at(int i);
		return win_base + dense_tab[i];
	endfunction

	function automatic int slot_for(longint v);
		longint d;
		d = v - win_base;
		if (d < 0 || d >= win_span)
			return -1;
		return slot_tab[int'(d)];
	endfunction

	function automatic void swap_slots(int i, int j);
		int a, b;
		if (i == j)
			return;
		a = dense_tab[i];
		b = dense_tab[j];
		dense_tab[i] = b;
		dense_tab[j] = a;
		slot_tab[a] = j;
		slot_tab[b] = i;
	endfunction

	function automatic void rescan();
		longint v;
		if (live_n == 0)
			return;
		lo_bound = value_at(0);
		hi_bound = lo_bound;
		for (int i = 1; i < live_n; i++) begin
			v = value_at(i);
			if (v < lo_bound) lo_bound = v;
			if (v > hi_bound) hi_bound = v;
		end
	endfunction

	function automatic bit trim(longint t, bit above);
		bit kept;
		int i;
		longint v;
		kept = 1'b0;
		if (above ? (t >= hi_bound) : (t <= lo_bound))
			return 1'b1;
		if (above ? (t < lo_bound) : (t > hi_bound))
			return 1'b0;
		for (i = 0; i < live_n; i++) begin
			v = value_at(i);
			if (above ? (v <= t) : (v >= t))
				kept = 1'b1;
		end
		if (!kept)
			return 1'b0;
		i = 0;
		while (i < live_n) begin
			v = value_at(i);
			if (above ? (v > t) : (v < t)) begin
				swap_slots(i, live_n - 1);
				live_n--;
			end else begin
				i++;
			end
		end
		rescan();
		return 1'b1;
	endfunction

	function automatic ssid_pkg::rsp_t apply_domain_op(ssid_pkg::req_t r);
		ssid_pkg::rsp_t e;
		longint v;
		int s;
		e = '0;
		e.ok = 1'b1;
		v = sext(r.operand_value);
		case (r.op)
			ssid_pkg::OP_QUERY: begin
				s = slot_for(v);
				if (v >= lo_bound && v <= hi_bound && s >= 0 && s < live_n) begin
					e.found = 1'b1;
					e.position = 10'(s);
				end
			end
			ssid_pkg::OP_REMOVE: begin
				s = slot_for(v);
				if (s >= 0 && s < live_n) begin
					if (live_n == 1) begin
						e.ok = 1'b0;
					end else begin
						swap_slots(s, live_n - 1);
						live_n--;
						if (v == lo_bound || v == hi_bound)
							rescan();
					end
				end
			end
			ssid_pkg::OP_BELOW: e.ok = trim(v, 1'b0);
			ssid_pkg::OP_ABOVE: e.ok = trim(v, 1'b1);
			ssid_pkg::OP_ASSIGN: begin
				s = slot_for(v);
				if (s < 0 || s >= live_n) begin
					e.ok = 1'b0;
				end else begin
					swap_slots(s, 0);
					live_n = 1;
					lo_bound = v;
					hi_bound = v;
				end
			end
			ssid_pkg::OP_RESTORE: begin
				live_n = (int'(r.restore_count) > win_span) ? win_span : int'(r.restore_count);
				lo_bound = sext(r.restore_min);
				hi_bound = sext(r.restore_max);
			end
			ssid_pkg::OP_REINIT: domain_reinit();
			default: e.ok = 1'b0;
		endcase
		e.live_count = 11'(live_n);
		e.cur_min = 32'(lo_bound);
		e.cur_max = 32'(hi_bound);
		return e;
	endfunction

	task automatic send_item(ssid_pkg::req_t r);
		trail_t snap;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		snap.n = live_n;
		snap.lo = lo_bound;
		snap.hi = hi_bound;
		trail = {trail, snap};
		if (trail.size() > 16)
			void'(trail.pop_front());
		expected_results = {expected_results, apply_domain_op(r)};
		items_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == ssid_pkg::CFG_BASE)
			reg_base = sext(data);
		else
			reg_span = int'(data[10:0]);
		@(posedge clk);
	endtask

	function automatic ssid_pkg::req_t make_req(logic [2:0] op, longint v);
		ssid_pkg::req_t r;
		r = '0;
		r.op = op;
		r.operand_value = 32'(v);
		r.restore_count = 11'($urandom);
		r.restore_min = $urandom;
		r.restore_max = $urandom;
		return r;
	endfunction

	function automatic longint pick_value();
		if ($urandom_range(0, 9) == 0)
			return sext($urandom);
		return win_base + $urandom_range(0, win_span + 5) - 3;
	endfunction

	task automatic reconfigure(logic [31:0] base, logic [31:0] span);
		drain();
		write_reg(ssid_pkg::CFG_BASE, base);
		write_reg(ssid_pkg::CFG_SPAN, span);
		send_item(make_req(ssid_pkg::OP_REINIT, 0));
	endtask

	task automatic test_directed();
		ssid_pkg::req_t r;
		send_item(make_req(ssid_pkg::OP_QUERY, 0));
		send_item(make_req(ssid_pkg::OP_QUERY, 1023));
		send_item(make_req(ssid_pkg::OP_QUERY, -1));
		send_item(make_req(ssid_pkg::OP_QUERY, 64'sd2147483647));
		send_item(make_req(ssid_pkg::OP_QUERY, -64'sd2147483648));
		send_item(make_req(ssid_pkg::OP_REMOVE, 0));
		send_item(make_req(ssid_pkg::OP_REMOVE, 1023));
		send_item(make_req(ssid_pkg::OP_REMOVE, 500));
		send_item(make_req(ssid_pkg::OP_REMOVE, 5000));
		send_item(make_req(ssid_pkg::OP_QUERY, 500));
		send_item(make_req(ssid_pkg::OP_BELOW, 0));
		send_item(make_req(ssid_pkg::OP_ABOVE, 2000));
		send_item(make_req(ssid_pkg::OP_BELOW, 2000));
		send_item(make_req(ssid_pkg::OP_ABOVE, -10));
		send_item(make_req(ssid_pkg::OP_BELOW, 900));
		send_item(make_req(ssid_pkg::OP_ABOVE, 960));
		send_item(make_req(ssid_pkg::OP_ASSIGN, 10));
		send_item(make_req(ssid_pkg::OP_ASSIGN, 930));
		send_item(make_req(ssid_pkg::OP_REMOVE, 930));
		r = make_req(ssid_pkg::OP_RESTORE, 0);
		r.restore_count = 11'h7FF;
		send_item(r);
		send_item(make_req(ssid_pkg::OP_RESTORE, 0));
		send_item(make_req(OP_UNUSED, 930));
		send_item(make_req(ssid_pkg::OP_REINIT, 0));
		send_item(make_req(ssid_pkg::OP_QUERY, 700));
	endtask

	task automatic test_random(int n);
		ssid_pkg::req_t r;
		trail_t t;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 22)
				r = make_req(ssid_pkg::OP_QUERY, pick_value());
			else if (k < 45)
				r = make_req(ssid_pkg::OP_REMOVE, pick_value());
			else if (k < 57)
				r = make_req(ssid_pkg::OP_BELOW, pick_value());
			else if (k < 69)
				r = make_req(ssid_pkg::OP_ABOVE, pick_value());
			else if (k < 77)
				r = make_req(ssid_pkg::OP_ASSIGN, pick_value());
			else if (k < 94) begin
				r = make_req(ssid_pkg::OP_RESTORE, pick_value());
				if (k < 91 && trail.size() != 0) begin
					t = trail[$urandom_range(0, trail.size() - 1)];
					r.restore_count = 11'(t.n);
					r.restore_min = 32'(t.lo);
					r.restore_max = 32'(t.hi);
				end
			end else if (k < 97)
				r = make_req(ssid_pkg::OP_REINIT, pick_value());
			else
				r = make_req(OP_UNUSED, pick_value());
			send_item(r);
		end
	endtask

	always @(posedge clk) begin
		ready_cycle <= ready_cycle + 1;
		if (ready_cycle % 256 == 0)
			stall_pct <= (ready_cycle % 1024 == 0) ? 0 : 30 * $urandom_range(0, 3);
		rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		ssid_pkg::rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, rsp);
				error_count++;
			end else begin
				e = expected_results.pop_front();
				results_checked++;
				if (rsp.ok !== e.ok) begin
					$display("%0t: ok expected %0d got %0d", $time, e.ok, rsp.ok);
					error_count++;
				end
				if (rsp.found !== e.found) begin
					$display("%0t: found expected %0d got %0d", $time, e.found, rsp.found);
					error_count++;
				end
				if (rsp.position !== e.position) begin
					$display("%0t: position expected %0d got %0d", $time,
						e.position, rsp.position);
					error_count++;
				end
				if (rsp.live_count !== e.live_count) begin
					$display("%0t: live_count expected %0d got %0d", $time,
						e.live_count, rsp.live_count);
					error_count++;
				end
				if (rsp.cur_min !== e.cur_min) begin
					$display("%0t: cur_min expected %0d got %0d", $time,
						e.cur_min, rsp.cur_min);
					error_count++;
				end
				if (rsp.cur_max !== e.cur_max) begin
					$display("%0t: cur_max expected %0d got %0d", $time,
						e.cur_max, rsp.cur_max);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		domain_reinit();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(ssid_pkg::CFG_BASE, 32'd0);
		write_reg(ssid_pkg::CFG_SPAN, 32'd1024);
		test_directed();
		test_random(150);
		reconfigure(32'hFFFF_FFFB, 32'd10);
		test_random(350);
		reconfigure(32'h7FFF_FFFC, 32'd100);
		test_random(200);
		reconfigure(32'h8000_0000, 32'd0);
		test_random(50);
		reconfigure(32'h8000_0000, 32'd1);
		test_random(100);
		reconfigure($urandom, 32'd64);
		test_random(300);
		reconfigure(32'h0001_0000, 32'h7FF);
		test_random(100);
		drain();
		$display("Sent %0d domain operations over seven base/span settings,", items_sent);
		$display("checked %0d results.", results_checked);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
